### rtl/rfs_pkg.sv
package rfs_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int FRACTION_BITS = 16;

    localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ROW_W      = IDX_W + 2;
    localparam int TABLE_ROWS = TABLE_ENTRIES * 4;
    localparam int PWM_SHIFT  = 2 * FRACTION_BITS - 16;

    localparam int LEVEL_W = 24;
    localparam int STEP_W  = 6;
    localparam int STEP_CODES = 64;

    // item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_LOAD    = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_RAMP_MODE    = 3'd0;
    localparam logic [2:0] CFG_LAST_STEP    = 3'd1;
    localparam logic [2:0] CFG_BRIGHT_MUL   = 3'd2;
    localparam logic [2:0] CFG_RED_COEF     = 3'd3;
    localparam logic [2:0] CFG_GREEN_COEF   = 3'd4;
    localparam logic [2:0] CFG_BLUE_COEF    = 3'd5;
    localparam logic [2:0] CFG_PWM_LIMIT    = 3'd6;
    localparam logic [2:0] CFG_OUTPUTS_HELD = 3'd7;

    typedef struct packed {
        logic [1:0]          kind;
        logic [STEP_W-1:0]   entry_index;
        logic [LEVEL_W-1:0]  goal_brightness;
        logic [LEVEL_W-1:0]  rate_brightness;
        logic [LEVEL_W-1:0]  goal_red;
        logic [LEVEL_W-1:0]  rate_red;
        logic [LEVEL_W-1:0]  goal_green;
        logic [LEVEL_W-1:0]  rate_green;
        logic [LEVEL_W-1:0]  goal_blue;
        logic [LEVEL_W-1:0]  rate_blue;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pwm_red;
        logic [15:0] pwm_green;
        logic [15:0] pwm_blue;
    } out_item_t;

    // six-bit index folded into the table depth
    function automatic logic [STEP_CODES*IDX_W-1:0] entry_mod_f();
        logic [STEP_CODES*IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < STEP_CODES; i++)
        begin
            r[i*IDX_W +: IDX_W] = IDX_W'(i % TABLE_ENTRIES);
        end
        return r;
    endfunction

    localparam logic [STEP_CODES*IDX_W-1:0] ENTRY_MOD = entry_mod_f();

    // one ramp step toward the goal, no overshoot
    function automatic logic [LEVEL_W-1:0] approach_f(
        input logic [LEVEL_W-1:0] level,
        input logic [LEVEL_W-1:0] rate,
        input logic [LEVEL_W-1:0] goal
    );
        logic [LEVEL_W-1:0] res;
        if (level > goal)
        begin
            res = ((level - goal) <= rate) ? goal : level - rate;
        end
        else
        begin
            res = ((goal - level) <= rate) ? goal : level + rate;
        end
        return res;
    endfunction

endpackage

### rtl/rgb_fade_sequencer_core.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | rfs_pkg::in_item_t
// out     | out_valid / out_stall| rfs_pkg::out_item_t
// cfg     | cfg_we               | cfg_addr, cfg_wdata
//
// tick: ramp, four passes through each color lane's multiplier, sum, saturate,
//   into the result register; a held tick only ramps
// load: four table rows through the single memory write port
// advance: four rows through the registered memory read port
// async reset clears control, levels and active goals/rates and sets config defaults;
//   the step table is not cleared, so there is no clearing pass
// a stalled result holds the tick in its final step; the result register
//   frees the input side once the result is parked
module rgb_fade_sequencer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rfs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output rfs_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);
    import rfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ADV,
        S_RAMP,
        S_MUL_A,
        S_MUL_C,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [2:0]         cnt_reg;
    in_item_t           item_reg;

    // configuration registers
    logic               ramp_mode_reg;
    logic [STEP_W-1:0]  last_step_reg;
    logic [15:0]        bright_mul_reg;
    logic [15:0]        coef_reg [3];
    logic [15:0]        pwm_limit_reg;
    logic               held_reg;

    // sequencer state: brightness, red, green, blue
    logic [STEP_W-1:0]  step_index_reg;
    logic [LEVEL_W-1:0] goal_reg  [4];
    logic [LEVEL_W-1:0] rate_reg  [4];
    logic [LEVEL_W-1:0] level_reg [4];

    logic               out_valid_reg;
    out_item_t          out_item_reg;

    // step table: one row per entry and channel, {goal, rate}
    logic [2*LEVEL_W-1:0] table_mem [TABLE_ROWS];
    logic [2*LEVEL_W-1:0] rd_data_reg;
    logic [ROW_W-1:0]     rd_addr;
    logic [ROW_W-1:0]     wr_addr;
    logic [2*LEVEL_W-1:0] wr_data;
    logic                 mem_we;
    logic [IDX_W-1:0]     load_entry;
    logic [IDX_W-1:0]     step_entry;

    // per color lane multiplier and its partial products
    logic [31:0] op_x [3];
    logic [31:0] op_y [3];
    logic [63:0] prod [3];
    logic [47:0] a_reg  [3];
    logic [31:0] c_reg  [3];
    logic [63:0] lo_reg [3];
    logic [47:0] hi_reg [3];
    logic [47:0] q_reg  [3];
    logic [47:0] mid    [3];
    logic [15:0] sat    [3];

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign load_entry = ENTRY_MOD[item_reg.entry_index * IDX_W +: IDX_W];
    assign step_entry = ENTRY_MOD[step_index_reg * IDX_W +: IDX_W];
    assign mem_we     = (state_reg == S_LOAD);
    assign wr_addr    = {load_entry, cnt_reg[1:0]};
    assign rd_addr    = {step_entry, cnt_reg[1:0]};

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0: wr_data = {item_reg.goal_brightness, item_reg.rate_brightness};
            2'd1: wr_data = {item_reg.goal_red, item_reg.rate_red};
            2'd2: wr_data = {item_reg.goal_green, item_reg.rate_green};
            default: wr_data = {item_reg.goal_blue, item_reg.rate_blue};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // operand select for each lane's multiplier
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            unique case (state_reg)
                S_MUL_A:
                begin
                    op_x[l] = {8'd0, level_reg[l+1]};
                    op_y[l] = {8'd0, level_reg[0]};
                end
                S_MUL_C:
                begin
                    op_x[l] = {16'd0, coef_reg[l]};
                    op_y[l] = {16'd0, bright_mul_reg};
                end
                S_MUL_LO:
                begin
                    op_x[l] = a_reg[l][31:0];
                    op_y[l] = c_reg[l];
                end
                S_MUL_HI:
                begin
                    op_x[l] = {16'd0, a_reg[l][47:32]};
                    op_y[l] = c_reg[l];
                end
                default:
                begin
                    op_x[l] = '0;
                    op_y[l] = '0;
                end
            endcase
            prod[l] = op_x[l] * op_y[l];
            // hi part stays below 2^48 - 2^32, so the sum fits
            mid[l]  = hi_reg[l] + {16'd0, lo_reg[l][63:32]};
            sat[l]  = (q_reg[l] > {32'd0, pwm_limit_reg}) ? pwm_limit_reg
                                                          : q_reg[l][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (state_reg == S_MUL_A)
            begin
                a_reg[l] <= prod[l][47:0];
            end
            if (state_reg == S_MUL_C)
            begin
                c_reg[l] <= prod[l][31:0];
            end
            if (state_reg == S_MUL_LO)
            begin
                lo_reg[l] <= prod[l];
            end
            if (state_reg == S_MUL_HI)
            begin
                hi_reg[l] <= prod[l][47:0];
            end
            if (state_reg == S_SUM)
            begin
                q_reg[l] <= mid[l] >> PWM_SHIFT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ramp_mode_reg  <= 1'b0;
            last_step_reg  <= STEP_W'(12);
            bright_mul_reg <= 16'd256;
            coef_reg[0]    <= 16'd256;
            coef_reg[1]    <= 16'd256;
            coef_reg[2]    <= 16'd256;
            pwm_limit_reg  <= 16'hFFFF;
            held_reg       <= 1'b0;
            step_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int ch = 0; ch < 4; ch++)
            begin
                goal_reg[ch]  <= '0;
                rate_reg[ch]  <= '0;
                level_reg[ch] <= '0;
            end
        end
        else
        begin
            // the final tick step handles the result register itself
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        item_reg <= in_item;
                        unique case (in_item.kind)
                            KIND_TICK:    state_reg <= S_RAMP;
                            KIND_ADVANCE: state_reg <= S_ADV;
                            KIND_LOAD:    state_reg <= S_LOAD;
                            default:      state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_ADV:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    // row k arrives in the cycle after its read
                    for (int ch = 0; ch < 4; ch++)
                    begin
                        if (cnt_reg == 3'(ch + 1))
                        begin
                            goal_reg[ch] <= rd_data_reg[2*LEVEL_W-1:LEVEL_W];
                            rate_reg[ch] <= rd_data_reg[LEVEL_W-1:0];
                        end
                    end
                    if (cnt_reg == 3'd4)
                    begin
                        if (step_index_reg >= last_step_reg)
                        begin
                            step_index_reg <= STEP_W'(1);
                        end
                        else
                        begin
                            step_index_reg <= step_index_reg + STEP_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_RAMP:
                begin
                    level_reg[0] <= approach_f(level_reg[0], rate_reg[0], goal_reg[0]);
                    if (!ramp_mode_reg)
                    begin
                        for (int ch = 1; ch < 4; ch++)
                        begin
                            level_reg[ch] <= approach_f(level_reg[ch], rate_reg[ch],
                                                        goal_reg[ch]);
                        end
                    end
                    state_reg <= held_reg ? S_IDLE : S_MUL_A;
                end
                S_MUL_A:  state_reg <= S_MUL_C;
                S_MUL_C:  state_reg <= S_MUL_LO;
                S_MUL_LO: state_reg <= S_MUL_HI;
                S_MUL_HI: state_reg <= S_SUM;
                S_SUM:    state_reg <= S_OUT;
                S_OUT:
                begin
                    // wait for the result register to free up
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_item_reg.pwm_red   <= sat[0];
                        out_item_reg.pwm_green <= sat[1];
                        out_item_reg.pwm_blue  <= sat[2];
                        state_reg              <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_RAMP_MODE:    ramp_mode_reg  <= cfg_wdata[0];
                    CFG_LAST_STEP:
                    begin
                        last_step_reg  <= cfg_wdata[STEP_W-1:0];
                        step_index_reg <= '0;
                    end
                    CFG_BRIGHT_MUL:   bright_mul_reg <= cfg_wdata;
                    CFG_RED_COEF:     coef_reg[0]    <= cfg_wdata;
                    CFG_GREEN_COEF:   coef_reg[1]    <= cfg_wdata;
                    CFG_BLUE_COEF:    coef_reg[2]    <= cfg_wdata;
                    CFG_PWM_LIMIT:    pwm_limit_reg  <= cfg_wdata;
                    CFG_OUTPUTS_HELD: held_reg       <= cfg_wdata[0];
                    default:          held_reg       <= held_reg;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // a result only appears from the final tick step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result without finished tick");

    // a stalled result keeps the next tick parked in its final step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> state_reg == S_OUT)
        else $error("tick result overran a waiting result");

    // a held tick ramps and ends without multiplying
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RAMP && held_reg) |=> state_reg == S_IDLE)
        else $error("held tick went on to the multipliers");

    // the step pointer moves only at the end of an advance or a last_step write
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(step_index_reg) |->
            ($past(state_reg == S_ADV) || $past(cfg_we && cfg_addr == CFG_LAST_STEP)))
        else $error("step index moved outside an advance");

    // table row sweeps stay within one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> cnt_reg <= 3'd3)
        else $error("load sweep ran past the last channel row");
`endif

endmodule
